### rtl/wbcm_pkg.sv
// wbcm_pkg: shared types, widths and constants for the white balance and
// color matrix block; used by every rtl file of the block, depends on nothing
package wbcm_pkg;

    // pixel and coefficient formats
    localparam int PIXEL_BITS     = 16;
    localparam int COEF_FRAC_BITS = 12;
    localparam int FIELD_W        = 16;
    localparam int GAIN_W         = 16;
    localparam int COEF_W         = 16;
    localparam int NUM_CH         = 3;
    localparam int ROW_W          = NUM_CH * COEF_W;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = ROW_W;

    // datapath widths
    localparam int BAL_PROD_W = PIXEL_BITS + GAIN_W;
    localparam int BAL_SHR_W  = BAL_PROD_W - COEF_FRAC_BITS;
    localparam int MAT_PROD_W = COEF_W + PIXEL_BITS + 1;
    localparam int SUM_W      = MAT_PROD_W + 2;
    localparam int SUM_SHR_W  = SUM_W - COEF_FRAC_BITS;

    // cycles from an accepted start to the done strobe
    localparam int PIPE_LATENCY = 5;

    localparam logic [PIXEL_BITS-1:0] PIX_MAX  = '1;
    localparam logic [GAIN_W-1:0]     GAIN_ONE = GAIN_W'(1) << COEF_FRAC_BITS;
    localparam logic signed [SUM_W-1:0] ROUND_HALF =
        SUM_W'(1) << (COEF_FRAC_BITS - 1);

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN_RED         = 3'd0,
        REG_GAIN_GREEN       = 3'd1,
        REG_GAIN_BLUE        = 3'd2,
        REG_MATRIX_ROW_RED   = 3'd3,
        REG_MATRIX_ROW_GREEN = 3'd4,
        REG_MATRIX_ROW_BLUE  = 3'd5
    } cfg_reg_t;

    // channel order inside arrays: red, green, blue
    localparam int CH_RED   = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 2;

    typedef logic [NUM_CH-1:0][PIXEL_BITS-1:0] chan_t;
    typedef logic [NUM_CH-1:0][GAIN_W-1:0]     gain_set_t;
    typedef logic [NUM_CH-1:0][ROW_W-1:0]      row_set_t;

    typedef struct packed {
        gain_set_t gain;
        row_set_t  row;
    } cfg_t;

    typedef struct packed {
        logic [FIELD_W-1:0] in_red;
        logic [FIELD_W-1:0] in_green;
        logic [FIELD_W-1:0] in_blue;
    } pixel_in_t;

    typedef struct packed {
        logic [FIELD_W-1:0] out_red;
        logic [FIELD_W-1:0] out_green;
        logic [FIELD_W-1:0] out_blue;
    } pixel_out_t;

    // identity row for output channel ch: coefficient one in slot ch
    function automatic logic [ROW_W-1:0] identity_row(input int ch);
        logic [ROW_W-1:0] r;
        r = '0;
        r[ch*COEF_W +: COEF_W] = COEF_W'(GAIN_ONE);
        return r;
    endfunction

endpackage

### rtl/wbcm_cfg_regs.sv
// wbcm_cfg_regs: gain and matrix row registers behind the plain write port
// depends on wbcm_pkg
module wbcm_cfg_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [wbcm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [wbcm_pkg::CFG_DATA_W-1:0] cfg_data,
    output wbcm_pkg::cfg_t                  cfg
);
    import wbcm_pkg::*;

    gain_set_t gain_reg;
    row_set_t  row_reg;

    // register writes, unknown indexes ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CH; i++)
            begin
                gain_reg[i] <= GAIN_ONE;
                row_reg[i]  <= identity_row(i);
            end
        end
        else if (cfg_write)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_GAIN_RED:         gain_reg[CH_RED]   <= cfg_data[GAIN_W-1:0];
                REG_GAIN_GREEN:       gain_reg[CH_GREEN] <= cfg_data[GAIN_W-1:0];
                REG_GAIN_BLUE:        gain_reg[CH_BLUE]  <= cfg_data[GAIN_W-1:0];
                REG_MATRIX_ROW_RED:   row_reg[CH_RED]    <= cfg_data[ROW_W-1:0];
                REG_MATRIX_ROW_GREEN: row_reg[CH_GREEN]  <= cfg_data[ROW_W-1:0];
                REG_MATRIX_ROW_BLUE:  row_reg[CH_BLUE]   <= cfg_data[ROW_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign cfg.gain = gain_reg;
    assign cfg.row  = row_reg;

endmodule

### rtl/wbcm_balance.sv
// wbcm_balance: two-stage white balance, gain multiply then truncate and
// saturate to the pixel range; depends on wbcm_pkg
module wbcm_balance (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                valid_in,
    input  wbcm_pkg::chan_t     pix,
    input  wbcm_pkg::gain_set_t gain,
    output logic                valid_out,
    output wbcm_pkg::chan_t     bal
);
    import wbcm_pkg::*;

    logic                  prod_valid_reg;
    logic                  bal_valid_reg;
    logic [BAL_PROD_W-1:0] prod_next [NUM_CH];
    logic [BAL_PROD_W-1:0] prod_reg  [NUM_CH];
    logic [BAL_SHR_W-1:0]  shr       [NUM_CH];
    chan_t                 bal_next;
    chan_t                 bal_reg;

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            bal_valid_reg  <= 1'b0;
        end
        else
        begin
            prod_valid_reg <= valid_in;
            bal_valid_reg  <= prod_valid_reg;
        end
    end

    // gain multiply
    always_comb
    begin
        for (int c = 0; c < NUM_CH; c++)
        begin
            prod_next[c] = BAL_PROD_W'(pix[c]) * BAL_PROD_W'(gain[c]);
        end
    end

    // drop fraction bits and saturate
    always_comb
    begin
        for (int c = 0; c < NUM_CH; c++)
        begin
            shr[c] = prod_reg[c][BAL_PROD_W-1:COEF_FRAC_BITS];
            if (|shr[c][BAL_SHR_W-1:PIXEL_BITS])
            begin
                bal_next[c] = PIX_MAX;
            end
            else
            begin
                bal_next[c] = shr[c][PIXEL_BITS-1:0];
            end
        end
    end

    // payload stages
    always_ff @(posedge clk)
    begin
        for (int c = 0; c < NUM_CH; c++)
        begin
            prod_reg[c] <= prod_next[c];
        end
        bal_reg <= bal_next;
    end

    assign valid_out = bal_valid_reg;
    assign bal       = bal_reg;

endmodule

### rtl/wbcm_matrix.sv
// wbcm_matrix: three-stage 3x3 color matrix: nine products, row sums, then
// clamp negative sums to zero, round half up and saturate; depends on wbcm_pkg
module wbcm_matrix (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               valid_in,
    input  wbcm_pkg::chan_t    bal,
    input  wbcm_pkg::row_set_t row,
    output logic               valid_out,
    output wbcm_pkg::chan_t    res
);
    import wbcm_pkg::*;

    logic                         prod_valid_reg;
    logic                         sum_valid_reg;
    logic                         res_valid_reg;
    logic signed [MAT_PROD_W-1:0] prod_next [NUM_CH][NUM_CH];
    logic signed [MAT_PROD_W-1:0] prod_reg  [NUM_CH][NUM_CH];
    logic signed [SUM_W-1:0]      sum_next  [NUM_CH];
    logic signed [SUM_W-1:0]      sum_reg   [NUM_CH];
    logic signed [SUM_W-1:0]      rnd       [NUM_CH];
    logic [SUM_SHR_W-1:0]         shr       [NUM_CH];
    chan_t                        res_next;
    chan_t                        res_reg;

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            sum_valid_reg  <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            prod_valid_reg <= valid_in;
            sum_valid_reg  <= prod_valid_reg;
            res_valid_reg  <= sum_valid_reg;
        end
    end

    // signed coefficient times unsigned balanced sample
    always_comb
    begin
        for (int r = 0; r < NUM_CH; r++)
        begin
            for (int c = 0; c < NUM_CH; c++)
            begin
                prod_next[r][c] =
                    MAT_PROD_W'($signed(row[r][c*COEF_W +: COEF_W])) *
                    $signed({1'b0, bal[c]});
            end
        end
    end

    // row sums
    always_comb
    begin
        for (int r = 0; r < NUM_CH; r++)
        begin
            sum_next[r] = SUM_W'(prod_reg[r][CH_RED]) + SUM_W'(prod_reg[r][CH_GREEN])
                        + SUM_W'(prod_reg[r][CH_BLUE]);
        end
    end

    // negative sums clamp to zero, others round up at half and saturate
    always_comb
    begin
        for (int r = 0; r < NUM_CH; r++)
        begin
            rnd[r] = sum_reg[r] + ROUND_HALF;
            shr[r] = rnd[r][SUM_W-1:COEF_FRAC_BITS];
            if (sum_reg[r][SUM_W-1])
            begin
                res_next[r] = '0;
            end
            else if (|shr[r][SUM_SHR_W-1:PIXEL_BITS])
            begin
                res_next[r] = PIX_MAX;
            end
            else
            begin
                res_next[r] = shr[r][PIXEL_BITS-1:0];
            end
        end
    end

    // payload stages
    always_ff @(posedge clk)
    begin
        for (int r = 0; r < NUM_CH; r++)
        begin
            for (int c = 0; c < NUM_CH; c++)
            begin
                prod_reg[r][c] <= prod_next[r][c];
            end
            sum_reg[r] <= sum_next[r];
        end
        res_reg <= res_next;
    end

    assign valid_out = res_valid_reg;
    assign res       = res_reg;

    // a negative red row sum leaves a zero red result
    a_neg_sum_zero: assert property (@(posedge clk) disable iff (!rst_n)
        sum_valid_reg && sum_reg[CH_RED][SUM_W-1] |=> res_reg[CH_RED] == '0)
        else $error("negative row sum did not clamp to zero");

    // a result beat always comes from a summed beat in the cycle before
    a_res_from_sum: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> $past(sum_valid_reg))
        else $error("result beat without a row sum beat");

endmodule

### rtl/white_balance_color_matrix_top.sv
// white_balance_color_matrix_top: top level of the white balance and color
// matrix block; depends on wbcm_pkg, wbcm_cfg_regs, wbcm_balance, wbcm_matrix
//
// One RGB pixel is taken on every clock at which start is high; busy is
// always low, so the block never refuses a pixel. Each pixel comes out on
// result with a one-cycle done strobe after it has gone through its stages:
// two stages of white balance (gain multiply, truncate and saturate) and
// three of color matrix (nine products, row sums, clamp, round and saturate).
// Results are not held, so the receiver must take each one in its strobe
// cycle. Gains and matrix rows are written through cfg_write/cfg_index/
// cfg_data with no wait; write them only while no pixel is in flight.
module white_balance_color_matrix_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  wbcm_pkg::pixel_in_t             pixel,
    input  logic                            cfg_write,
    input  logic [wbcm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [wbcm_pkg::CFG_DATA_W-1:0] cfg_data,
    output logic                            done,
    output wbcm_pkg::pixel_out_t            result
);
    import wbcm_pkg::*;

    cfg_t  cfg;
    chan_t pix;
    chan_t bal;
    chan_t res;
    logic  bal_valid;
    logic  accept;

    // the pipeline never stalls
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // low pixel bits of each field
    assign pix[CH_RED]   = pixel.in_red[PIXEL_BITS-1:0];
    assign pix[CH_GREEN] = pixel.in_green[PIXEL_BITS-1:0];
    assign pix[CH_BLUE]  = pixel.in_blue[PIXEL_BITS-1:0];

    wbcm_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    wbcm_balance u_balance (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (accept),
        .pix       (pix),
        .gain      (cfg.gain),
        .valid_out (bal_valid),
        .bal       (bal)
    );

    wbcm_matrix u_matrix (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (bal_valid),
        .bal       (bal),
        .row       (cfg.row),
        .valid_out (done),
        .res       (res)
    );

    // result beat
    assign result.out_red   = FIELD_W'(res[CH_RED]);
    assign result.out_green = FIELD_W'(res[CH_GREEN]);
    assign result.out_blue  = FIELD_W'(res[CH_BLUE]);

    // every accepted pixel gives a done strobe after the fixed latency
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##PIPE_LATENCY done)
        else $error("accepted pixel gave no result at the pipeline latency");

    // no done strobe without a pixel taken at the pipeline latency before
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, PIPE_LATENCY))
        else $error("result beat without a matching accepted pixel");

endmodule
